[design/falru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_pkg
// Shared defaults and types for the fully associative LRU tag store.
// ----------------------------------------------------------------------------
package falru_pkg;

  // Default geometry
  localparam int ENTRIES_DEFAULT   = 16;
  localparam int KEY_WIDTH_DEFAULT = 32;

  // Outcome flags of one lookup
  typedef struct packed {
    logic evicted;
    logic hit;
  } falru_flags_t;

endpackage

[design/falru_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_store
// Tag array with occupancy and recency order: parallel match, free-slot
// and LRU selection, and a registered state update per lookup.
// ----------------------------------------------------------------------------
module falru_store import falru_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEFAULT,
  parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         lookup_en,
  input  logic [KEY_WIDTH-1:0]         lookup_key,
  input  logic [$clog2(ENTRIES+1)-1:0] entries_in_use,
  output falru_flags_t                 flags,
  output logic [$clog2(ENTRIES)-1:0]   slot_index,
  output logic [KEY_WIDTH-1:0]         evicted_key
);

  localparam int IW = $clog2(ENTRIES);
  localparam int RW = IW;
  localparam int CW = $clog2(ENTRIES+1);

  // Slot state
  logic [KEY_WIDTH-1:0] slot_keys [ENTRIES];
  logic [ENTRIES-1:0]   slot_occupied;
  logic [RW-1:0]        recency_rank [ENTRIES];
  logic [CW-1:0]        occ_count;

  logic [ENTRIES-1:0]   in_use;
  logic [ENTRIES-1:0]   match;
  logic [ENTRIES-1:0]   free;
  logic [ENTRIES-1:0]   cand;
  logic [ENTRIES-1:0]   lru_oh;
  logic [IW-1:0]        hit_idx;
  logic [IW-1:0]        free_idx;
  logic [IW-1:0]        lru_idx;
  logic [IW-1:0]        sel_idx;
  logic [RW-1:0]        sel_rank;
  logic                 any_hit;
  logic                 any_free;
  logic                 evict;

  logic [ENTRIES-1:0]   slot_occupied_next;
  logic [RW-1:0]        recency_rank_next [ENTRIES];
  logic [CW-1:0]        occ_count_next;

  // Compare the key against every slot in use
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      in_use[i] = CW'(i) < entries_in_use;
      cand[i]   = slot_occupied[i] & in_use[i];
      match[i]  = cand[i] & (slot_keys[i] == lookup_key);
      free[i]   = ~slot_occupied[i] & in_use[i];
    end
  end

  // Mark the occupied slot in use that no other such slot predates
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      lru_oh[i] = cand[i];
      for (int j = 0; j < ENTRIES; j++) begin
        if (j != i && cand[j] && recency_rank[j] < recency_rank[i]) begin
          lru_oh[i] = 1'b0;
        end
      end
    end
  end

  // Encode: lowest matching slot, highest free slot, the LRU slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    lru_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IW'(i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (free[i]) begin
        free_idx = IW'(i);
      end
      if (lru_oh[i]) begin
        lru_idx = IW'(i);
      end
    end
  end

  // Pick the slot that holds the key after this lookup
  always_comb begin
    any_hit  = |match;
    any_free = |free;
    evict    = ~any_hit & ~any_free;
    if (any_hit) begin
      sel_idx = hit_idx;
    end else if (any_free) begin
      sel_idx = free_idx;
    end else begin
      sel_idx = lru_idx;
    end
    sel_rank = recency_rank[sel_idx];
  end

  // Recency and occupancy update
  always_comb begin
    slot_occupied_next = slot_occupied;
    occ_count_next     = occ_count;
    for (int j = 0; j < ENTRIES; j++) begin
      recency_rank_next[j] = recency_rank[j];
    end
    if (!any_hit && any_free) begin
      // Allocate a free slot at the top of the order
      recency_rank_next[sel_idx]  = RW'(occ_count);
      slot_occupied_next[sel_idx] = 1'b1;
      occ_count_next              = occ_count + CW'(1);
    end else begin
      // Move the selected slot to the top, close the gap behind it
      for (int j = 0; j < ENTRIES; j++) begin
        if (slot_occupied[j] && recency_rank[j] > sel_rank) begin
          recency_rank_next[j] = recency_rank[j] - RW'(1);
        end
      end
      recency_rank_next[sel_idx] = RW'(occ_count - CW'(1));
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_occupied <= '0;
      occ_count     <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        recency_rank[j] <= '0;
      end
    end else if (lookup_en) begin
      slot_occupied <= slot_occupied_next;
      occ_count     <= occ_count_next;
      for (int j = 0; j < ENTRIES; j++) begin
        recency_rank[j] <= recency_rank_next[j];
      end
    end
  end

  // Store the new key on a miss
  always_ff @(posedge clk) begin
    if (lookup_en && !any_hit) begin
      slot_keys[sel_idx] <= lookup_key;
    end
  end

  assign flags.hit     = any_hit;
  assign flags.evicted = evict;
  assign slot_index    = sel_idx;
  assign evicted_key   = evict ? slot_keys[lru_idx] : '0;

endmodule

[design/fully_assoc_lru_tag_store_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_assoc_lru_tag_store_core
// Fully associative tag store with LRU replacement: one lookup per key,
// reporting hit, slot and any evicted key.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_*       in         lookup key
//  m_*       out        hit, slot index, evicted flag, evicted key
//  cfg_*     in         entries_in_use register write
//
//  One lookup is accepted per clock while m_* is not stalled; its result
//  reaches m_* via the input register, then the result register. The rate
//  is set by the combinational compare and recency update over all slots.
//  Reset empties all slots and sets entries_in_use to ENTRIES.
//  With m_tready low the result holds, and s_tready drops once the input
//  register is also full.
// ----------------------------------------------------------------------------
module fully_assoc_lru_tag_store_core import falru_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEFAULT,
  parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  // cfg: entries_in_use
  input  logic                                        cfg_wr_en,
  input  logic [$clog2(ENTRIES+1)-1:0]                cfg_wr_data,
  // s_tdata: lookup_key
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  input  logic [((KEY_WIDTH+7)/8)*8-1:0]              s_tdata,
  // m_tdata: slot_index, evicted_key
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  output logic [(($clog2(ENTRIES)+KEY_WIDTH+7)/8)*8-1:0] m_tdata,
  // m_tuser: hit, evicted
  output logic [1:0]                                  m_tuser
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES+1);
  localparam int OW = ((IW + KEY_WIDTH + 7) / 8) * 8;

  logic [CW-1:0]        entries_in_use;
  logic                 in_valid;
  logic [KEY_WIDTH-1:0] in_key;
  logic                 advance;
  falru_flags_t         flags;
  logic [IW-1:0]        slot_index;
  logic [KEY_WIDTH-1:0] evicted_key;

  // Clamp and hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CW'(ENTRIES);
    end else if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        entries_in_use <= CW'(1);
      end else if (cfg_wr_data > CW'(ENTRIES)) begin
        entries_in_use <= CW'(ENTRIES);
      end else begin
        entries_in_use <= cfg_wr_data;
      end
    end
  end

  // Advance the input register into the result register
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_key <= s_tdata[KEY_WIDTH-1:0];
    end
  end

  falru_store #(
    .ENTRIES   (ENTRIES),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_store (
    .clk            (clk),
    .rst            (rst),
    .lookup_en      (advance),
    .lookup_key     (in_key),
    .entries_in_use (entries_in_use),
    .flags          (flags),
    .slot_index     (slot_index),
    .evicted_key    (evicted_key)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= OW'({evicted_key, slot_index});
      m_tuser <= {flags.evicted, flags.hit};
    end
  end

endmodule

[design/falru_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falru_checker
// Port-level checks on the LRU tag store results, bound to the top level.
// ----------------------------------------------------------------------------
module falru_checker import falru_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEFAULT,
  parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
  input logic                                            clk,
  input logic                                            rst,
  input logic                                            m_tvalid,
  input logic                                            m_tready,
  input logic [(($clog2(ENTRIES)+KEY_WIDTH+7)/8)*8-1:0]  m_tdata,
  input logic [1:0]                                      m_tuser
);

  localparam int IW = $clog2(ENTRIES);

  // A transaction never reports a hit and an eviction together
  a_evict_not_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("eviction reported on a hit");

  // Evicted key reads as zero unless a slot was replaced
  a_evkey_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[IW+KEY_WIDTH-1:IW] == '0)
    else $error("evicted key nonzero without eviction");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind fully_assoc_lru_tag_store_core falru_checker #(
  .ENTRIES   (ENTRIES),
  .KEY_WIDTH (KEY_WIDTH)
) u_falru_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[sim/fully_assoc_lru_tag_store_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_assoc_lru_tag_store_core_test
// Self-checking bench for the LRU tag store. A behavioral copy of the slot
// table (keys, occupancy, recency ranks) predicts every lookup result. The
// bench runs directed lookups over several slot counts, then random key
// streams drawn mostly from a small shared key pool so that hits, fills and
// evictions all occur. Both stream sides idle at random, and one phase
// stalls the result side long enough to back up the input.
// ----------------------------------------------------------------------------
module fully_assoc_lru_tag_store_core_test;
  import falru_pkg::*;

  localparam int ENTRIES   = ENTRIES_DEFAULT;
  localparam int KEY_W     = KEY_WIDTH_DEFAULT;
  localparam int CFG_W     = $clog2(ENTRIES + 1);
  localparam int SLOT_W    = $clog2(ENTRIES);
  localparam int S_DATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int M_DATA_W  = ((SLOT_W + KEY_W + 7) / 8) * 8;
  localparam int POOL_SIZE = ENTRIES + 4;

  typedef struct {
    bit              hit;
    bit [SLOT_W-1:0] slot;
    bit              evicted;
    bit [KEY_W-1:0]  evicted_key;
  } lookup_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;     // lookup_key
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;          // slot_index, evicted_key
  logic [1:0]          m_tuser;          // hit, evicted

  fully_assoc_lru_tag_store_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always #6 clk = ~clk;

  // Shadow slot table
  bit [KEY_W-1:0] slot_key   [ENTRIES];
  bit             slot_valid [ENTRIES];
  int             slot_rank  [ENTRIES];
  int             active_slots = ENTRIES;

  lookup_result_t pending_results[$];
  bit [KEY_W-1:0] key_pool[POOL_SIZE];
  int             mismatch_count = 0;
  bit             tx_idle_on = 1'b1;
  bit             rx_idle_on = 1'b1;
  int             rx_hold_cycles = 0;
  int             rx_stall_left = 0;

  function automatic int count_occupied();
    int c;
    c = 0;
    for (int j = 0; j < ENTRIES; j++) c += int'(slot_valid[j]);
    return c;
  endfunction

  // Make occupied slot s the most recently used
  function automatic void promote_slot(int s);
    int r;
    int cnt;
    r = slot_rank[s];
    cnt = count_occupied();
    for (int j = 0; j < ENTRIES; j++)
      if (slot_valid[j] && slot_rank[j] > r) slot_rank[j]--;
    slot_rank[s] = cnt - 1;
  endfunction

  // Predict one lookup and update the shadow table
  function automatic lookup_result_t predict_lookup(bit [KEY_W-1:0] key);
    lookup_result_t res;
    int free_slot;
    int lru_slot;
    res = '{default: 0};
    free_slot = -1;
    lru_slot = -1;
    for (int i = 0; i < active_slots; i++) begin
      if (!slot_valid[i]) begin
        free_slot = i;
      end else if (slot_key[i] == key) begin
        promote_slot(i);
        res.hit = 1'b1;
        res.slot = SLOT_W'(i);
        return res;
      end else if (lru_slot < 0 || slot_rank[i] < slot_rank[lru_slot]) begin
        lru_slot = i;
      end
    end
    if (free_slot >= 0) begin
      res.slot = SLOT_W'(free_slot);
      slot_rank[free_slot] = count_occupied();
      slot_valid[free_slot] = 1'b1;
    end else begin
      res.slot = SLOT_W'(lru_slot);
      res.evicted = 1'b1;
      res.evicted_key = slot_key[lru_slot];
      promote_slot(lru_slot);
    end
    slot_key[res.slot] = key;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [KEY_W-1:0] got,
                                 logic [KEY_W-1:0] want);
    if (mismatch_count < 40)
      $display("%0t ns: %s got %h, want %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Offer one key and record its expected result on acceptance
  task automatic send_lookup(bit [KEY_W-1:0] key);
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = key;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_lookup(key));
  endtask

  // Drop valid and hold until every expected result has arrived
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write entries_in_use while idle; mirror the clamp in the shadow copy
  task automatic write_entries(int value);
    wait_drained();
    cfg_wr_en = 1'b1;
    cfg_wr_data = CFG_W'(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    active_slots = (value < 1) ? 1 : (value > ENTRIES) ? ENTRIES : value;
  endtask

  // Mostly pool keys sized to the active slots, some fully random keys
  function automatic bit [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 78)
      return key_pool[$urandom_range(0, active_slots + 3)];
    return $urandom;
  endfunction

  // Result side: long hold, random stall bursts, else ready
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      m_tready = 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else if (rx_stall_left > 0) begin
      m_tready = 1'b0;
      rx_stall_left = rx_stall_left - 1;
    end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
      m_tready = 1'b0;
      rx_stall_left = $urandom_range(0, 13);
    end else begin
      m_tready = 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    lookup_result_t want;
    falru_flags_t   flags;
    if (!rst && m_tvalid && m_tready) begin
      flags = m_tuser;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, slot", KEY_W'(m_tdata[SLOT_W-1:0]), '0);
      end else begin
        want = pending_results.pop_front();
        if (flags.hit !== want.hit)
          report_mismatch("hit", KEY_W'(flags.hit), KEY_W'(want.hit));
        if (m_tdata[SLOT_W-1:0] !== want.slot)
          report_mismatch("slot_index", KEY_W'(m_tdata[SLOT_W-1:0]),
                          KEY_W'(want.slot));
        if (flags.evicted !== want.evicted)
          report_mismatch("evicted", KEY_W'(flags.evicted), KEY_W'(want.evicted));
        if (m_tdata[SLOT_W+KEY_W-1:SLOT_W] !== want.evicted_key)
          report_mismatch("evicted_key", m_tdata[SLOT_W+KEY_W-1:SLOT_W],
                          want.evicted_key);
      end
    end
  end

  // Extreme keys, hit and eviction on two slots, clamped register values
  task automatic test_directed();
    write_entries(2);
    send_lookup('0);
    send_lookup('1);
    send_lookup('0);
    send_lookup(32'h5A5A_A5A5);
    send_lookup('1);
    send_lookup(32'h8000_0001);
    // Register 0 acts as one slot; parked slots keep their keys
    write_entries(0);
    send_lookup(32'h8000_0001);
    send_lookup('1);
    send_lookup(32'h7FFF_FFFE);
    send_lookup(32'h7FFF_FFFE);
    // Above ENTRIES acts as ENTRIES; parked keys come back as hits
    write_entries((1 << CFG_W) - 1);
    send_lookup('1);
    send_lookup(32'h5A5A_A5A5);
    send_lookup('0);
    send_lookup(32'h7FFF_FFFE);
    send_lookup(32'h0000_0001);
    send_lookup(32'h8000_0000);
    wait_drained();
  endtask

  // Result side holds off while keys keep coming, so the input backs up
  task automatic test_receiver_hold();
    write_entries(ENTRIES);
    @(posedge clk);
    rx_hold_cycles = 80;
    repeat (30) send_lookup(pick_key());
    wait_drained();
  endtask

  // Sender stops until every result is back, then resumes
  task automatic test_sender_pause();
    repeat (20) send_lookup(pick_key());
    wait_drained();
    repeat (20) send_lookup(pick_key());
    wait_drained();
  endtask

  // Random key streams over a sweep of slot counts
  task automatic test_random_phases();
    int settings[10];
    settings = '{ENTRIES, 1, 5, 31, 0, 9, ENTRIES + 1, 3, 12, ENTRIES};
    foreach (settings[p]) begin
      write_entries(settings[p]);
      // Keep the final phase free of idling on both sides
      if (p == 9) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      repeat (165) send_lookup(pick_key());
    end
    wait_drained();
  endtask

  initial begin
    foreach (key_pool[k]) key_pool[k] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    foreach (slot_valid[k]) begin
      slot_valid[k] = 1'b0;
      slot_rank[k] = 0;
      slot_key[k] = '0;
    end
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_receiver_hold();
    test_sender_pause();
    test_random_phases();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("fully_assoc_lru_tag_store_core: match");
    else
      $display("fully_assoc_lru_tag_store_core: mismatch");
    $finish;
  end

  // Hard stop if the stream hangs
  initial begin
    #6_000_000;
    $display("fully_assoc_lru_tag_store_core: mismatch");
    $finish;
  end

endmodule

[sim.f]
design/falru_pkg.sv
design/falru_store.sv
design/fully_assoc_lru_tag_store_core.sv
design/falru_checker.sv
sim/fully_assoc_lru_tag_store_core_test.sv
